>>> rtl/core/sps_pkg.sv
// shared types and constants of the strict priority scheduler
package sps_pkg;

  // default sizing
  localparam int unsigned QUEUE_DEPTH_DEF = 128;
  localparam int unsigned NUM_LEVELS_DEF  = 4;

  // field widths of an item and a stored job entry
  localparam int unsigned JOB_W   = 8;
  localparam int unsigned RUN_W   = 5;
  localparam int unsigned PRIO_W  = 2;
  localparam int unsigned ENTRY_W = JOB_W + RUN_W;

  // item kinds
  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RAN    = 2'd1,
    ST_ACCEPT = 2'd2,
    ST_DROP   = 2'd3
  } status_e;

  // control sequencer states
  typedef enum logic {
    S_ACCEPT = 1'b0,
    S_SERVE  = 1'b1
  } state_e;

  // queue update command from the sequencer to the queue state
  typedef struct packed {
    logic push;
    logic serve;
    logic fin;
  } q_cmd_t;

endpackage

>>> rtl/core/strict_priority_fcfs_scheduler.sv
// top level of the strict priority first-come-first-served scheduler
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i, in_stall_o | kind_i, job_id_i, priority_req_i,
//          |                        | run_quanta_i
//  out     | out_valid_o,out_stall_i| status_o, served_job_o, served_level_o,
//          |                        | first_run_o, finished_o
//
// an arrival or a tick with all queues empty loads the result directly; a tick
// that serves a job first reads the registered job store, then loads the result
// one item is in work at a time; the next is taken as the result register frees
// reset clears pointers, counts and head quanta at once; the job store is not
// cleared, since only entries written by arrivals are ever read
// a stalled result holds the block from taking a new item
module strict_priority_fcfs_scheduler #(
  parameter int unsigned QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned NUM_LEVELS  = sps_pkg::NUM_LEVELS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [sps_pkg::JOB_W-1:0]  job_id_i,
  input  logic [sps_pkg::PRIO_W-1:0] priority_req_i,
  input  logic [sps_pkg::RUN_W-1:0]  run_quanta_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [sps_pkg::JOB_W-1:0]  served_job_o,
  output logic [sps_pkg::PRIO_W-1:0] served_level_o,
  output logic                       first_run_o,
  output logic                       finished_o
);

  localparam int unsigned LVL_W  = $clog2(NUM_LEVELS);
  localparam int unsigned IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned DEPTH  = NUM_LEVELS * QUEUE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] QD_A = ADDR_W'(QUEUE_DEPTH);

  sps_pkg::state_e state_q, state_d;
  sps_pkg::q_cmd_t cmd;

  logic                        out_free;
  logic                        in_fire;
  logic [LVL_W-1:0]            arr_lvl;
  logic [LVL_W-1:0]            acc_lvl;
  logic [LVL_W-1:0]            pick_q;
  logic                        pick_valid;
  logic [LVL_W-1:0]            pick_lvl;
  logic                        full;
  logic [IDX_W-1:0]            head_idx;
  logic [IDX_W-1:0]            tail_idx;
  logic [sps_pkg::RUN_W-1:0]   head_quanta;
  logic [sps_pkg::RUN_W-1:0]   served;
  logic [sps_pkg::RUN_W-1:0]   need;
  logic [ADDR_W-1:0]           mem_addr;
  logic                        mem_we;
  logic                        mem_re;
  logic [sps_pkg::ENTRY_W-1:0] rdata;

  logic                        load;
  sps_pkg::status_e            status_d;
  logic [sps_pkg::JOB_W-1:0]   job_d;
  logic [sps_pkg::PRIO_W-1:0]  level_d;
  logic                        first_d;
  logic                        fin_d;

  logic                        out_valid_q;
  sps_pkg::status_e            status_q;
  logic [sps_pkg::JOB_W-1:0]   job_q;
  logic [sps_pkg::PRIO_W-1:0]  level_q;
  logic                        first_q;
  logic                        fin_q;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != sps_pkg::S_ACCEPT) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  // arrival level saturates to the last level
  assign arr_lvl = (int'(priority_req_i) > NUM_LEVELS - 1) ?
                   LVL_W'(NUM_LEVELS - 1) : LVL_W'(priority_req_i);

  // one level looked at per cycle
  always_comb begin
    if (state_q == sps_pkg::S_SERVE) begin
      acc_lvl = pick_q;
    end else if (kind_i == sps_pkg::KIND_TICK) begin
      acc_lvl = pick_lvl;
    end else begin
      acc_lvl = arr_lvl;
    end
  end

  // job store address: level row plus fifo index
  assign mem_addr = ADDR_W'(acc_lvl) * QD_A +
                    ADDR_W'((kind_i == sps_pkg::KIND_TICK) ? head_idx : tail_idx);

  // required and served quanta of the head job
  assign need   = rdata[sps_pkg::ENTRY_W-1:sps_pkg::JOB_W];
  assign served = head_quanta + sps_pkg::RUN_W'(1);

  sps_queue_state #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_LEVELS  (NUM_LEVELS),
    .LVL_W       (LVL_W),
    .IDX_W       (IDX_W)
  ) u_queue_state (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .acc_lvl_i       (acc_lvl),
    .served_quanta_i (served),
    .pick_valid_o    (pick_valid),
    .pick_lvl_o      (pick_lvl),
    .full_o          (full),
    .head_o          (head_idx),
    .tail_o          (tail_idx),
    .head_quanta_o   (head_quanta)
  );

  sps_job_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_job_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i ({run_quanta_i, job_id_i}),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sps_pkg::S_ACCEPT: begin
        if (in_fire && kind_i == sps_pkg::KIND_TICK && pick_valid) begin
          state_d = sps_pkg::S_SERVE;
        end
      end
      sps_pkg::S_SERVE: begin
        if (out_free) begin
          state_d = sps_pkg::S_ACCEPT;
        end
      end
      default: state_d = sps_pkg::S_ACCEPT;
    endcase
  end

  // sequencer outputs and result
  always_comb begin
    cmd      = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    load     = 1'b0;
    status_d = sps_pkg::ST_IDLE;
    job_d    = '0;
    level_d  = '0;
    first_d  = 1'b0;
    fin_d    = 1'b0;
    unique case (state_q)
      sps_pkg::S_ACCEPT: begin
        if (in_fire) begin
          if (kind_i == sps_pkg::KIND_ARRIVAL) begin
            load    = 1'b1;
            job_d   = job_id_i;
            level_d = sps_pkg::PRIO_W'(arr_lvl);
            if (full) begin
              status_d = sps_pkg::ST_DROP;
            end else begin
              status_d = sps_pkg::ST_ACCEPT;
              mem_we   = 1'b1;
              cmd.push = 1'b1;
            end
          end else if (pick_valid) begin
            mem_re = 1'b1;
          end else begin
            load = 1'b1;
          end
        end
      end
      sps_pkg::S_SERVE: begin
        if (out_free) begin
          load      = 1'b1;
          status_d  = sps_pkg::ST_RAN;
          job_d     = rdata[sps_pkg::JOB_W-1:0];
          level_d   = sps_pkg::PRIO_W'(pick_q);
          first_d   = (head_quanta == '0);
          fin_d     = (served >= need);
          cmd.serve = 1'b1;
          cmd.fin   = fin_d;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sps_pkg::S_ACCEPT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // served level and result payload
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      pick_q <= pick_lvl;
    end
    if (load) begin
      status_q <= status_d;
      job_q    <= job_d;
      level_q  <= level_d;
      first_q  <= first_d;
      fin_q    <= fin_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign served_job_o   = job_q;
  assign served_level_o = level_q;
  assign first_run_o    = first_q;
  assign finished_o     = fin_q;

endmodule

>>> rtl/core/sps_job_mem.sv
// job entry store: one write port, one registered read port
module sps_job_mem #(
  parameter int unsigned DEPTH  = sps_pkg::QUEUE_DEPTH_DEF * sps_pkg::NUM_LEVELS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [sps_pkg::ENTRY_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [sps_pkg::ENTRY_W-1:0] rdata_o
);

  logic [sps_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [sps_pkg::ENTRY_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sps_queue_state.sv
// per-level fifo pointers, fill counts, head quanta and the priority pick
module sps_queue_state #(
  parameter int unsigned QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned NUM_LEVELS  = sps_pkg::NUM_LEVELS_DEF,
  parameter int unsigned LVL_W       = $clog2(NUM_LEVELS),
  parameter int unsigned IDX_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sps_pkg::q_cmd_t           cmd_i,
  input  logic [LVL_W-1:0]          acc_lvl_i,
  input  logic [sps_pkg::RUN_W-1:0] served_quanta_i,
  output logic                      pick_valid_o,
  output logic [LVL_W-1:0]          pick_lvl_o,
  output logic                      full_o,
  output logic [IDX_W-1:0]          head_o,
  output logic [IDX_W-1:0]          tail_o,
  output logic [sps_pkg::RUN_W-1:0] head_quanta_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  logic [IDX_W-1:0]          head_q  [NUM_LEVELS];
  logic [CNT_W-1:0]          count_q [NUM_LEVELS];
  logic [sps_pkg::RUN_W-1:0] hsq_q   [NUM_LEVELS];

  logic [IDX_W-1:0] acc_head;
  logic [CNT_W-1:0] acc_count;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] head_next;

  // highest non-empty level, level 0 wins
  always_comb begin
    pick_valid_o = 1'b0;
    pick_lvl_o   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count_q[i] != '0) begin
        pick_valid_o = 1'b1;
        pick_lvl_o   = LVL_W'(i);
      end
    end
  end

  // single access level view
  assign acc_head      = head_q[acc_lvl_i];
  assign acc_count     = count_q[acc_lvl_i];
  assign head_quanta_o = hsq_q[acc_lvl_i];
  assign head_o        = acc_head;
  assign full_o        = (acc_count == FULL_CNT);

  // tail index wraps once at most
  assign tail_sum = SUM_W'(acc_head) + SUM_W'(acc_count);
  assign tail_o   = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);

  assign head_next = (acc_head == LAST_IDX) ? '0 : acc_head + IDX_W'(1);

  // pointer and count updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
        hsq_q[i]   <= '0;
      end
    end else if (cmd_i.push) begin
      count_q[acc_lvl_i] <= acc_count + CNT_W'(1);
    end else if (cmd_i.serve) begin
      if (cmd_i.fin) begin
        hsq_q[acc_lvl_i]   <= '0;
        head_q[acc_lvl_i]  <= head_next;
        count_q[acc_lvl_i] <= acc_count - CNT_W'(1);
      end else begin
        hsq_q[acc_lvl_i] <= served_quanta_i;
      end
    end
  end

endmodule

>>> rtl/core/sps_checker.sv
// port-level checks of the scheduler, bound to the top level
module sps_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       kind_i,
  input logic [sps_pkg::JOB_W-1:0]  job_id_i,
  input logic [sps_pkg::PRIO_W-1:0] priority_req_i,
  input logic [sps_pkg::RUN_W-1:0]  run_quanta_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [1:0]                 status_o,
  input logic [sps_pkg::JOB_W-1:0]  served_job_o,
  input logic [sps_pkg::PRIO_W-1:0] served_level_o,
  input logic                       first_run_o,
  input logic                       finished_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(served_job_o) && $stable(served_level_o) && $stable(first_run_o) &&
    $stable(finished_o))
    else $error("stalled result changed");

  // a blocked result blocks the input side
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("item taken while result stalled");

  // an arrival answers in the next cycle with its own id
  a_arrival_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i == sps_pkg::KIND_ARRIVAL |=>
    out_valid_o && served_job_o == $past(job_id_i) &&
    (status_o == sps_pkg::ST_ACCEPT || status_o == sps_pkg::ST_DROP))
    else $error("arrival result missing or wrong");

  // idle and arrival results carry no run flags
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sps_pkg::ST_RAN |-> !first_run_o && !finished_o)
    else $error("run flags set outside a served tick");

endmodule

bind strict_priority_fcfs_scheduler sps_checker u_sps_checker (.*);

>>> bench/strict_priority_fcfs_scheduler_test.sv
// self-checking testbench of the strict priority fcfs scheduler
`timescale 1ns / 100ps

module strict_priority_fcfs_scheduler_test;

  localparam int unsigned QDEPTH    = sps_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned NLEV      = sps_pkg::NUM_LEVELS_DEF;
  localparam int unsigned CYCLE_CAP = 300000;
  localparam int unsigned DRAIN_GAP = 8;
  localparam int unsigned PHASE_LEN = 160;
  localparam int unsigned FLOOD_LEN = QDEPTH + 4;
  localparam int unsigned HOLD_LEN  = 300;

  // one result item as the block reports it
  typedef struct packed {
    sps_pkg::status_e           status;
    logic [sps_pkg::JOB_W-1:0]  job;
    logic [sps_pkg::PRIO_W-1:0] level;
    logic                       first;
    logic                       fin;
  } sched_result_t;

  // tracks the per-level job queues and the results they must produce
  class sched_ledger;
    logic [sps_pkg::JOB_W-1:0] slot_job  [NLEV][QDEPTH];
    logic [sps_pkg::RUN_W-1:0] slot_runq [NLEV][QDEPTH];
    int unsigned               head      [NLEV];
    int unsigned               count     [NLEV];
    logic [sps_pkg::RUN_W-1:0] done_q    [NLEV];
    sched_result_t             due_results[$];
    int unsigned               errors;

    function new();
      for (int l = 0; l < NLEV; l++) begin
        head[l]   = 0;
        count[l]  = 0;
        done_q[l] = '0;
      end
      errors = 0;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // work out the result of one accepted item and update the queues
    function void note_item(logic kind, logic [sps_pkg::JOB_W-1:0] id,
                            logic [sps_pkg::PRIO_W-1:0] prio,
                            logic [sps_pkg::RUN_W-1:0] runq);
      sched_result_t             res;
      int unsigned               lvl;
      int unsigned               tail;
      bit                        found;
      logic [sps_pkg::RUN_W-1:0] served;
      res   = '{status: sps_pkg::ST_IDLE, job: '0, level: '0, first: 1'b0, fin: 1'b0};
      found = 1'b0;
      if (kind == sps_pkg::KIND_ARRIVAL) begin
        lvl = prio;
        if (lvl > NLEV - 1) lvl = NLEV - 1;
        res.job   = id;
        res.level = sps_pkg::PRIO_W'(lvl);
        if (count[lvl] >= QDEPTH) begin
          res.status = sps_pkg::ST_DROP;
        end else begin
          tail = (head[lvl] + count[lvl]) % QDEPTH;
          slot_job[lvl][tail]  = id;
          slot_runq[lvl][tail] = runq;
          count[lvl]++;
          res.status = sps_pkg::ST_ACCEPT;
        end
      end else begin
        // highest non-empty level wins
        for (int l = 0; l < NLEV; l++) begin
          if (!found && count[l] != 0) begin
            found      = 1'b1;
            served     = done_q[l] + 1'b1;
            res.status = sps_pkg::ST_RAN;
            res.job    = slot_job[l][head[l]];
            res.level  = sps_pkg::PRIO_W'(l);
            res.first  = (done_q[l] == '0);
            res.fin    = (served >= slot_runq[l][head[l]]);
            if (res.fin) begin
              done_q[l] = '0;
              head[l]   = (head[l] + 1) % QDEPTH;
              count[l]--;
            end else begin
              done_q[l] = served;
            end
          end
        end
      end
      due_results.push_back(res);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(sched_result_t got);
      sched_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d job %0d", got.status, got.job);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.job !== want.job) begin
        $error("served_job: expected %0d, got %0d", want.job, got.job);
        errors++;
      end
      if (got.level !== want.level) begin
        $error("served_level: expected %0d, got %0d", want.level, got.level);
        errors++;
      end
      if (got.first !== want.first) begin
        $error("first_run: expected %0d, got %0d", want.first, got.first);
        errors++;
      end
      if (got.fin !== want.fin) begin
        $error("finished: expected %0d, got %0d", want.fin, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic                       kind      = sps_pkg::KIND_ARRIVAL;
  logic [sps_pkg::JOB_W-1:0]  job_id    = '0;
  logic [sps_pkg::PRIO_W-1:0] prio_req  = '0;
  logic [sps_pkg::RUN_W-1:0]  run_q     = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 status;
  logic [sps_pkg::JOB_W-1:0]  served_job;
  logic [sps_pkg::PRIO_W-1:0] served_level;
  logic                       first_run;
  logic                       finished;

  sched_ledger ledger;
  int unsigned cycles    = 0;
  int unsigned send_idle = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_left = 0;

  strict_priority_fcfs_scheduler u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .job_id_i       (job_id),
    .priority_req_i (prio_req),
    .run_quanta_i   (run_q),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .served_job_o   (served_job),
    .served_level_o (served_level),
    .first_run_o    (first_run),
    .finished_o     (finished)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: check accepted results, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      ledger.check_result('{status: sps_pkg::status_e'(status), job: served_job,
                            level: served_level, first: first_run, fin: finished});
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // offer one item, with random gaps before it, and wait for its handshake
  task automatic put_item(logic k, logic [sps_pkg::JOB_W-1:0] id,
                          logic [sps_pkg::PRIO_W-1:0] p, logic [sps_pkg::RUN_W-1:0] r);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    job_id   <= id;
    prio_req <= p;
    run_q    <= r;
    do @(posedge clk); while (in_stall);
    ledger.note_item(k, id, p, r);
  endtask

  task automatic arrive(logic [sps_pkg::JOB_W-1:0] id, logic [sps_pkg::PRIO_W-1:0] p,
                        logic [sps_pkg::RUN_W-1:0] r);
    put_item(sps_pkg::KIND_ARRIVAL, id, p, r);
  endtask

  // tick with random content in the ignored fields
  task automatic tick();
    put_item(sps_pkg::KIND_TICK, sps_pkg::JOB_W'($urandom_range(0, 255)),
             sps_pkg::PRIO_W'($urandom_range(0, 3)), sps_pkg::RUN_W'($urandom_range(0, 31)));
  endtask

  // sender pauses until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // mostly ticks with short jobs so queues drain; some long or zero-length jobs
  task automatic random_item();
    logic [sps_pkg::RUN_W-1:0] rq;
    if ($urandom_range(0, 99) < 10) rq = sps_pkg::RUN_W'($urandom_range(0, 31));
    else rq = sps_pkg::RUN_W'($urandom_range(1, 4));
    if ($urandom_range(0, 99) < 28) begin
      arrive(sps_pkg::JOB_W'($urandom_range(0, 255)), sps_pkg::PRIO_W'($urandom_range(0, 3)),
             rq);
    end else begin
      tick();
    end
  endtask

  // fill one level past its depth so that arrivals get dropped
  task automatic flood_level(logic [sps_pkg::PRIO_W-1:0] lvl);
    for (int i = 0; i < FLOOD_LEN; i++) begin
      arrive(sps_pkg::JOB_W'($urandom_range(0, 255)), lvl,
             sps_pkg::RUN_W'($urandom_range(0, 2)));
    end
  endtask

  int unsigned send_plan [8] = '{0, 51, 0, 16, 0, 51, 0, 16};
  int unsigned stall_plan[8] = '{0, 0, 51, 16, 0, 0, 51, 16};

  initial begin
    ledger = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, extremes, zero and maximum run lengths, preemption
    tick();
    arrive(8'h00, 2'd3, 5'd31);
    tick();
    tick();
    arrive(8'hFF, 2'd0, 5'd0);
    tick();
    arrive(8'h5A, 2'd1, 5'd16);
    arrive(8'hA5, 2'd2, 5'd1);
    tick();
    arrive(8'h3C, 2'd0, 5'd2);
    tick();
    tick();
    tick();
    arrive(8'hC3, 2'd1, 5'd17);
    arrive(8'h81, 2'd2, 5'd1);
    tick();
    tick();
    wait_drained();

    // random phases with varied idling on both sides
    for (int ph = 0; ph < 8; ph++) begin
      send_idle = send_plan[ph];
      stall_pct = stall_plan[ph];
      if (ph == 1 || ph == 5) flood_level(sps_pkg::PRIO_W'($urandom_range(0, 3)));
      // long receiver hold-off while the sender keeps pushing
      if (ph == 4) hold_req = HOLD_LEN;
      for (int i = 0; i < PHASE_LEN; i++) random_item();
      wait_drained();
    end

    repeat (DRAIN_GAP) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
